// ===== rtl/core/lsgs_pkg.sv =====
// shared types and constants for the led strip grid serializer
// no dependencies

package lsgs_pkg;

    localparam int FUNC_W   = 2;
    localparam int IDX_W    = 6;
    localparam int COLOR_W  = 24;
    localparam int DUTY_W   = 16;
    localparam int BIT_W    = 5;
    localparam int MAX_COLS = 4;

    localparam logic [BIT_W-1:0] LED_MSB  = 5'd23;
    localparam logic [DUTY_W-1:0] ZERO_DUTY_RST = 16'd8;
    localparam logic [DUTY_W-1:0] ONE_DUTY_RST  = 16'd16;

    localparam logic [FUNC_W-1:0] FUNC_SET    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SCROLL = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FETCH  = 2'd2;

    localparam logic CFG_ZERO_DUTY = 1'b0;
    localparam logic CFG_ONE_DUTY  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SET,
        ST_SCROLL,
        ST_SC_WR,
        ST_FE_RD,
        ST_FE_OUT
    } lsgs_state_t;

    typedef struct packed {
        logic capture;
        logic set_wr;
        logic scroll_rd;
        logic scroll_wr;
        logic scroll_top;
        logic fetch_rd;
        logic fetch_out;
    } lsgs_cmd_t;

    typedef struct packed {
        logic row_nonzero;
        logic last_col;
        logic out_busy;
    } lsgs_status_t;

endpackage

// ===== rtl/core/lsgs_ram.sv =====
// generic single write port ram with registered read
// no dependencies

module lsgs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 40
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/lsgs_ctrl.sv =====
// sequencer for set, scroll and fetch words
// depends on lsgs_pkg

module lsgs_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [lsgs_pkg::FUNC_W-1:0]  in_func,
    output logic                         in_ready,
    input  lsgs_pkg::lsgs_status_t       status,
    output lsgs_pkg::lsgs_cmd_t          cmd
);

    lsgs_pkg::lsgs_state_t state_reg;
    lsgs_pkg::lsgs_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lsgs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lsgs_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_func)
                        lsgs_pkg::FUNC_SET:    state_next = lsgs_pkg::ST_SET;
                        lsgs_pkg::FUNC_SCROLL: state_next = lsgs_pkg::ST_SCROLL;
                        lsgs_pkg::FUNC_FETCH:  state_next = lsgs_pkg::ST_FE_RD;
                        default:               state_next = lsgs_pkg::ST_IDLE;
                    endcase
                end
            end
            lsgs_pkg::ST_SET:
            begin
                state_next = lsgs_pkg::ST_IDLE;
            end
            lsgs_pkg::ST_SCROLL:
            begin
                if (status.row_nonzero)
                begin
                    state_next = lsgs_pkg::ST_SC_WR;
                end
                else if (status.last_col)
                begin
                    state_next = lsgs_pkg::ST_IDLE;
                end
            end
            lsgs_pkg::ST_SC_WR:
            begin
                state_next = lsgs_pkg::ST_SCROLL;
            end
            lsgs_pkg::ST_FE_RD:
            begin
                state_next = lsgs_pkg::ST_FE_OUT;
            end
            lsgs_pkg::ST_FE_OUT:
            begin
                if (!status.out_busy)
                begin
                    state_next = lsgs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lsgs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            lsgs_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            lsgs_pkg::ST_SET:
            begin
                cmd.set_wr = 1'b1;
            end
            lsgs_pkg::ST_SCROLL:
            begin
                cmd.scroll_rd  = status.row_nonzero;
                cmd.scroll_top = !status.row_nonzero;
            end
            lsgs_pkg::ST_SC_WR:
            begin
                cmd.scroll_wr = 1'b1;
            end
            lsgs_pkg::ST_FE_RD:
            begin
                cmd.fetch_rd = 1'b1;
            end
            lsgs_pkg::ST_FE_OUT:
            begin
                cmd.fetch_out = !status.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/lsgs_dp.sv =====
// datapath: colour store, valid bits, slot pointer, duty registers, output word
// depends on lsgs_pkg and lsgs_ram

module lsgs_dp #(
    parameter int COLUMNS     = 4,
    parameter int ROWS        = 10,
    parameter int RESET_SLOTS = 40
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  lsgs_pkg::lsgs_cmd_t                        cmd,
    output lsgs_pkg::lsgs_status_t                     status,
    input  logic [lsgs_pkg::IDX_W-1:0]                 in_idx,
    input  logic [lsgs_pkg::MAX_COLS*lsgs_pkg::COLOR_W-1:0] in_colors,
    input  logic                                       cfg_we,
    input  logic                                       cfg_index,
    input  logic [lsgs_pkg::DUTY_W-1:0]                cfg_data,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output logic [lsgs_pkg::DUTY_W-1:0]                out_duty,
    output logic                                       out_last
);

    localparam int LED_COUNT = COLUMNS * ROWS;
    localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int RW = $clog2(ROWS);
    localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int GW = (RESET_SLOTS > 1) ? $clog2(RESET_SLOTS) : 1;

    logic [lsgs_pkg::IDX_W-1:0]   idx_reg;
    logic [lsgs_pkg::COLOR_W-1:0] color_reg [COLUMNS];

    logic [AW-1:0] dst_reg;
    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_reg;

    logic [LED_COUNT-1:0] valid_reg;
    logic                 rvalid_reg;

    logic                 in_gap_reg;
    logic [AW-1:0]        led_cnt_reg;
    logic [lsgs_pkg::BIT_W-1:0] bit_cnt_reg;
    logic [GW-1:0]        gap_cnt_reg;

    logic [lsgs_pkg::DUTY_W-1:0] zero_duty_reg;
    logic [lsgs_pkg::DUTY_W-1:0] one_duty_reg;

    logic                        out_valid_reg;
    logic [lsgs_pkg::DUTY_W-1:0] out_duty_reg;
    logic                        out_last_reg;

    logic [lsgs_pkg::IDX_W-1:0]   idx_m1;
    logic                         idx_ok;
    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic [lsgs_pkg::COLOR_W-1:0] mem_wdata;
    logic                         mem_re;
    logic [AW-1:0]                mem_raddr;
    logic [lsgs_pkg::COLOR_W-1:0] mem_rdata;
    logic [lsgs_pkg::COLOR_W-1:0] rd_color;
    logic [lsgs_pkg::BIT_W-1:0]   bit_pos;
    logic                         slot_last;
    logic [lsgs_pkg::DUTY_W-1:0]  slot_duty;

    assign idx_m1 = idx_reg - 6'd1;
    assign idx_ok = (idx_reg != '0) && ({1'b0, idx_reg} <= 7'(LED_COUNT));

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = dst_reg;
        mem_wdata = rd_color;
        if (cmd.set_wr)
        begin
            mem_we    = idx_ok;
            mem_waddr = idx_m1[AW-1:0];
            mem_wdata = color_reg[0];
        end
        else if (cmd.scroll_wr)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.scroll_top)
        begin
            mem_we    = 1'b1;
            mem_wdata = color_reg[col_reg];
        end
    end

    assign mem_re    = cmd.scroll_rd || cmd.fetch_rd;
    assign mem_raddr = cmd.scroll_rd ? (dst_reg - 1'b1) : led_cnt_reg;
    assign rd_color  = rvalid_reg ? mem_rdata : '0;

    lsgs_ram #(
        .WIDTH (lsgs_pkg::COLOR_W),
        .DEPTH (LED_COUNT)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // input word capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            idx_reg <= in_idx;
            for (int c = 0; c < COLUMNS; c++)
            begin
                color_reg[c] <= in_colors[c*lsgs_pkg::COLOR_W +: lsgs_pkg::COLOR_W];
            end
        end
    end

    // scroll walk, bottom kept row excluded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dst_reg <= '0;
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (cmd.capture)
        begin
            dst_reg <= AW'(ROWS - 2);
            row_reg <= RW'(ROWS - 2);
            col_reg <= '0;
        end
        else if (cmd.scroll_wr)
        begin
            dst_reg <= dst_reg - 1'b1;
            row_reg <= row_reg - 1'b1;
        end
        else if (cmd.scroll_top)
        begin
            dst_reg <= dst_reg + AW'(2 * ROWS - 2);
            row_reg <= RW'(ROWS - 2);
            col_reg <= col_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                valid_reg[mem_waddr] <= 1'b1;
            end
            if (mem_re)
            begin
                rvalid_reg <= valid_reg[mem_raddr];
            end
        end
    end

    assign status.row_nonzero = (row_reg != '0);
    assign status.last_col    = (col_reg == CW'(COLUMNS - 1));
    assign status.out_busy    = out_valid_reg && !out_ready;

    // slot pointer
    assign bit_pos   = lsgs_pkg::LED_MSB - bit_cnt_reg;
    assign slot_last = in_gap_reg && (gap_cnt_reg == GW'(RESET_SLOTS - 1));
    assign slot_duty = in_gap_reg ? '0 :
                       (rd_color[bit_pos] ? one_duty_reg : zero_duty_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_gap_reg  <= 1'b0;
            led_cnt_reg <= '0;
            bit_cnt_reg <= '0;
            gap_cnt_reg <= '0;
        end
        else if (cmd.fetch_out)
        begin
            if (in_gap_reg)
            begin
                if (slot_last)
                begin
                    in_gap_reg  <= 1'b0;
                    led_cnt_reg <= '0;
                    bit_cnt_reg <= '0;
                end
                else
                begin
                    gap_cnt_reg <= gap_cnt_reg + 1'b1;
                end
            end
            else if (bit_cnt_reg == lsgs_pkg::LED_MSB)
            begin
                bit_cnt_reg <= '0;
                if (led_cnt_reg == AW'(LED_COUNT - 1))
                begin
                    in_gap_reg  <= 1'b1;
                    gap_cnt_reg <= '0;
                end
                else
                begin
                    led_cnt_reg <= led_cnt_reg + 1'b1;
                end
            end
            else
            begin
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_duty_reg <= lsgs_pkg::ZERO_DUTY_RST;
            one_duty_reg  <= lsgs_pkg::ONE_DUTY_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lsgs_pkg::CFG_ZERO_DUTY: zero_duty_reg <= cfg_data;
                lsgs_pkg::CFG_ONE_DUTY:  one_duty_reg  <= cfg_data;
                default:                 zero_duty_reg <= zero_duty_reg;
            endcase
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.fetch_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fetch_out)
        begin
            out_duty_reg <= slot_duty;
            out_last_reg <= slot_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_duty  = out_duty_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== rtl/core/led_strip_grid_serializer_top.sv =====
// top level of the led strip grid serializer
// depends on lsgs_pkg, lsgs_ctrl, lsgs_dp and lsgs_ram
//
// channel   dir  signals                          contents
// s_*       in   tvalid tready tdata tuser        set, scroll or fetch word
// m_*       out  tvalid tready tdata tlast        slot duty word
// cfg_*     in   we index data                    zero_duty, one_duty
//
// a scroll moves rows through the single read and write port of the colour
// store, one row move per read plus write. one word in flight at a time;
// s_tready is high only when idle.
// the output register holds a duty word while the next word is accepted; a
// fetch waits in its output state only while that register is full and m_tready is low.
// reset clears colour valid bits and slot pointer and loads the duty registers at once.

module led_strip_grid_serializer_top #(
    parameter int COLUMNS     = 4,
    parameter int ROWS        = 10,
    parameter int RESET_SLOTS = 40
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // led_index[5:0], color0[29:6], color1[53:30], color2[77:54], color3[101:78]
    input  logic [103:0] s_tdata,
    // func[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // duty[15:0]
    output logic [15:0]  m_tdata,
    output logic         m_tlast,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_data
);

    lsgs_pkg::lsgs_cmd_t    cmd;
    lsgs_pkg::lsgs_status_t status;

    lsgs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_func  (s_tuser),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lsgs_dp #(
        .COLUMNS     (COLUMNS),
        .ROWS        (ROWS),
        .RESET_SLOTS (RESET_SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_idx    (s_tdata[5:0]),
        .in_colors (s_tdata[101:6]),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_duty  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

// ===== tb/sv/led_strip_grid_serializer_top_tb.sv =====
// testbench for led_strip_grid_serializer_top: set, scroll and fetch words against a
// cycle-free prediction of the colour store, slot pointer and duty registers
// depends on lsgs_pkg and the rtl of led_strip_grid_serializer_top

module led_strip_grid_serializer_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLUMNS      = 4;
    localparam int ROWS         = 10;
    localparam int RESET_SLOTS  = 40;
    localparam int LEDS         = COLUMNS * ROWS;
    localparam int COLOUR_SLOTS = 24 * LEDS;
    localparam int FRAME_SLOTS  = COLOUR_SLOTS + RESET_SLOTS;
    localparam int DRAIN_CYCLES = 1 + COLUMNS * (2 * (ROWS - 2) + 1) + 20;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int CALM_FROM    = 2500;
    localparam int CALM_TO      = 4500;
    localparam int HOLD_CYCLES  = 500;

    localparam logic [lsgs_pkg::FUNC_W-1:0] FUNC_NONE = 2'd3;

    typedef struct packed {
        logic [lsgs_pkg::FUNC_W-1:0]                       func;
        logic [lsgs_pkg::IDX_W-1:0]                        idx;
        logic [lsgs_pkg::MAX_COLS-1:0][lsgs_pkg::COLOR_W-1:0] colours;
    } strip_word_t;

    typedef struct packed {
        logic [lsgs_pkg::DUTY_W-1:0] duty;
        logic                        last;
    } slot_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [15:0]  m_tdata;
    logic         m_tlast;
    logic         cfg_we = 1'b0;
    logic         cfg_index = 1'b0;
    logic [15:0]  cfg_data = '0;

    strip_word_t                  word_queue[$];
    slot_t                        due_slots[$];
    logic [lsgs_pkg::COLOR_W-1:0] led_store[LEDS];
    int                           slot_ptr;
    logic [lsgs_pkg::DUTY_W-1:0]  zero_duty_q;
    logic [lsgs_pkg::DUTY_W-1:0]  one_duty_q;
    int                           cycle = 0;
    int                           fails = 0;
    bit                           hold_go = 1'b0;
    bit                           hold_done = 1'b0;
    int                           hold_left = 0;
    slot_t                        head;

    led_strip_grid_serializer_top #(
        .COLUMNS     (COLUMNS),
        .ROWS        (ROWS),
        .RESET_SLOTS (RESET_SLOTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    task automatic advance_strip(input strip_word_t w);
        int   led;
        int   bitpos;
        slot_t res;
        case (w.func)
            lsgs_pkg::FUNC_SET:
            begin
                if (w.idx >= 1 && w.idx <= LEDS)
                    led_store[w.idx - 1] = w.colours[0];
            end
            lsgs_pkg::FUNC_SCROLL:
            begin
                for (int c = 0; c < COLUMNS; c++)
                begin
                    for (int r = ROWS - 2; r >= 1; r--)
                        led_store[c * ROWS + r] = led_store[c * ROWS + r - 1];
                    led_store[c * ROWS] = w.colours[c];
                end
            end
            lsgs_pkg::FUNC_FETCH:
            begin
                res.duty = '0;
                if (slot_ptr < COLOUR_SLOTS)
                begin
                    led = slot_ptr / 24;
                    bitpos = 23 - (slot_ptr % 24);
                    res.duty = led_store[led][bitpos] ? one_duty_q : zero_duty_q;
                end
                res.last = (slot_ptr + 1 >= FRAME_SLOTS);
                slot_ptr = res.last ? 0 : slot_ptr + 1;
                due_slots.push_back(res);
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic bit take_gap();
        if (cycle >= CALM_FROM && cycle < CALM_TO)
            return 1'b0;
        return $urandom_range(0, 99) < 8;
    endfunction

    function automatic strip_word_t make_word(input logic [lsgs_pkg::FUNC_W-1:0] func,
                                              input logic [lsgs_pkg::IDX_W-1:0] idx,
                                              input logic [lsgs_pkg::COLOR_W-1:0] c0,
                                              input logic [lsgs_pkg::COLOR_W-1:0] c1,
                                              input logic [lsgs_pkg::COLOR_W-1:0] c2,
                                              input logic [lsgs_pkg::COLOR_W-1:0] c3);
        strip_word_t w;
        w.func = func;
        w.idx = idx;
        w.colours = {c3, c2, c1, c0};
        return w;
    endfunction

    function automatic strip_word_t random_word(input logic [lsgs_pkg::FUNC_W-1:0] func);
        strip_word_t w;
        w.func = func;
        w.idx = lsgs_pkg::IDX_W'($urandom());
        for (int c = 0; c < lsgs_pkg::MAX_COLS; c++)
            w.colours[c] = lsgs_pkg::COLOR_W'($urandom());
        return w;
    endfunction

    task automatic queue_random(input int count);
        strip_word_t w;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                w = random_word(lsgs_pkg::FUNC_SET);
                if ($urandom_range(0, 9) != 0)
                    w.idx = lsgs_pkg::IDX_W'($urandom_range(1, LEDS));
            end
            else if (pick < 38)
                w = random_word(lsgs_pkg::FUNC_SCROLL);
            else if (pick < 42)
                w = random_word(FUNC_NONE);
            else
                w = random_word(lsgs_pkg::FUNC_FETCH);
            word_queue.push_back(w);
        end
    endtask

    // fetch through the end of the frame and a few slots into the next
    task automatic queue_frame_tail(input int extra);
        for (int n = 0; n < FRAME_SLOTS - slot_ptr + extra; n++)
            word_queue.push_back(random_word(lsgs_pkg::FUNC_FETCH));
    endtask

    task automatic settle();
        while (word_queue.size() != 0 || due_slots.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [lsgs_pkg::DUTY_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == lsgs_pkg::CFG_ZERO_DUTY)
            zero_duty_q = value;
        else
            one_duty_q = value;
    endtask

    // sender
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!(s_tvalid && !s_tready))
        begin
            if (s_tvalid && s_tready)
                advance_strip(word_queue.pop_front());
            if (word_queue.size() != 0 && !take_gap())
            begin
                s_tvalid <= 1'b1;
                s_tdata <= {2'b00, word_queue[0].colours, word_queue[0].idx};
                s_tuser <= word_queue[0].func;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver, with one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (hold_go && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
            m_tready <= !take_gap();
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (due_slots.size() == 0)
            begin
                $display("%0t: unexpected slot word duty %h last %b", $time, m_tdata, m_tlast);
                fails++;
            end
            else
            begin
                head = due_slots.pop_front();
                if (m_tdata !== head.duty)
                begin
                    $display("%0t: duty expected %h got %h", $time, head.duty, m_tdata);
                    fails++;
                end
                if (m_tlast !== head.last)
                begin
                    $display("%0t: last slot expected %b got %b", $time, head.last, m_tlast);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle >= CYCLE_LIMIT)
        begin
            $display("[led_strip_grid_serializer_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < LEDS; i++)
            led_store[i] = '0;
        slot_ptr = 0;
        zero_duty_q = lsgs_pkg::ZERO_DUTY_RST;
        one_duty_q = lsgs_pkg::ONE_DUTY_RST;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        word_queue.push_back(random_word(lsgs_pkg::FUNC_FETCH));
        word_queue.push_back(make_word(lsgs_pkg::FUNC_SET, 6'd1, 24'hffffff, '0, '0, '0));
        word_queue.push_back(make_word(lsgs_pkg::FUNC_SET, 6'd40, 24'h000001, '0, '0, '0));
        word_queue.push_back(make_word(lsgs_pkg::FUNC_SET, 6'd2, 24'ha5a5a5, '1, '1, '1));
        word_queue.push_back(make_word(lsgs_pkg::FUNC_SET, 6'd0, 24'h123456, '0, '0, '0));
        word_queue.push_back(make_word(lsgs_pkg::FUNC_SET, 6'd41, 24'hffffff, '0, '0, '0));
        word_queue.push_back(make_word(lsgs_pkg::FUNC_SET, 6'd63, 24'hffffff, '1, '1, '1));
        word_queue.push_back(make_word(FUNC_NONE, 6'd63, '1, '1, '1, '1));
        word_queue.push_back(make_word(lsgs_pkg::FUNC_SCROLL, 6'd0, 24'hffffff, 24'h000000,
                                       24'h800001, 24'h7ffffe));
        word_queue.push_back(make_word(lsgs_pkg::FUNC_SCROLL, 6'd63, 24'h5a5a5a, 24'hffffff,
                                       24'h000001, 24'h800000));
        word_queue.push_back(make_word(lsgs_pkg::FUNC_SET, 6'd10, 24'hf0f0f0, '0, '0, '0));
        for (int n = 0; n < 12; n++)
            word_queue.push_back(random_word(lsgs_pkg::FUNC_FETCH));
        settle();

        write_reg(lsgs_pkg::CFG_ZERO_DUTY, 16'h0000);
        write_reg(lsgs_pkg::CFG_ONE_DUTY, 16'hffff);
        queue_random(150);
        hold_go = 1'b1;
        settle();

        write_reg(lsgs_pkg::CFG_ZERO_DUTY, 16'($urandom()));
        write_reg(lsgs_pkg::CFG_ONE_DUTY, 16'($urandom()));
        queue_frame_tail(3);
        settle();

        if (fails == 0)
            $display("[led_strip_grid_serializer_top] OK");
        else
            $display("[led_strip_grid_serializer_top] ERROR");
        $finish;
    end

endmodule
